// ----- hdl/ppw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppw_pkg
// Shared types and constants of the periodic profile waveform generator:
// item structs, waveform select codes and the fixed-point sine constants.
// ----------------------------------------------------------------------------
package ppw_pkg;

    // waveform select codes
    typedef enum logic [1:0] {
        OP_NONE     = 2'd0,
        OP_SINE     = 2'd1,
        OP_SQUARE   = 2'd2,
        OP_TRIANGLE = 2'd3
    } ppw_op_t;

    // input item
    typedef struct packed {
        ppw_op_t            operation;
        logic signed [31:0] position;
        logic signed [31:0] amplitude;
        logic signed [31:0] phase_shift;
        logic signed [31:0] wavelength;
    } ppw_in_t;

    // result item
    typedef struct packed {
        logic signed [31:0] value;
        logic               bad_wavelength;
    } ppw_out_t;

    // one in Q30 and pi/2 in Q30
    localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

    // number of taylor terms in the horner chain
    localparam int HORNER_TERMS = 5;

    // horner denominators and their 2^34 reciprocals
    localparam logic [6:0] HORNER_DEN [HORNER_TERMS] = '{
        7'd110, 7'd72, 7'd42, 7'd20, 7'd6
    };
    localparam logic [31:0] HORNER_RECIP [HORNER_TERMS] = '{
        32'((64'd1 << 34) / 64'd110),
        32'((64'd1 << 34) / 64'd72),
        32'((64'd1 << 34) / 64'd42),
        32'((64'd1 << 34) / 64'd20),
        32'((64'd1 << 34) / 64'd6)
    };

endpackage

// ----- hdl/ppw_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppw_div
// Pipelined restoring divider, one quotient bit per stage. Takes a starting
// remainder below the divisor plus the dividend bits still to be brought
// down, and returns the low quotient bits, the remainder and a sideband
// vector that travels with the item.
// ----------------------------------------------------------------------------
module ppw_div #(
    parameter int DSR_W  = 31,
    parameter int STEPS  = 46,
    parameter int QUO_W  = 12,
    parameter int SIDE_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [DSR_W-1:0]  init_rem,
    input  logic [STEPS-1:0]  bits,
    input  logic [DSR_W-1:0]  divisor,
    input  logic [SIDE_W-1:0] side,
    output logic              out_valid,
    output logic [QUO_W-1:0]  quotient,
    output logic [DSR_W-1:0]  remainder,
    output logic [SIDE_W-1:0] out_side
);

    logic [STEPS-1:0]  vld_reg;
    logic [DSR_W-1:0]  rem_reg  [STEPS];
    logic [STEPS-1:0]  bits_reg [STEPS];
    logic [QUO_W-1:0]  quo_reg  [STEPS];
    logic [DSR_W-1:0]  dsr_reg  [STEPS];
    logic [SIDE_W-1:0] side_reg [STEPS];

    logic [STEPS-1:0]  p_vld;
    logic [DSR_W-1:0]  p_rem  [STEPS];
    logic [STEPS-1:0]  p_bits [STEPS];
    logic [QUO_W-1:0]  p_quo  [STEPS];
    logic [DSR_W-1:0]  p_dsr  [STEPS];
    logic [SIDE_W-1:0] p_side [STEPS];
    logic [DSR_W:0]    cand   [STEPS];
    logic [DSR_W:0]    diff   [STEPS];
    logic [STEPS-1:0]  take;

    // per-stage trial subtract
    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        if (i == 0)
        begin : g_first
            assign p_vld[i]  = in_valid;
            assign p_rem[i]  = init_rem;
            assign p_bits[i] = bits;
            assign p_quo[i]  = '0;
            assign p_dsr[i]  = divisor;
            assign p_side[i] = side;
        end
        else
        begin : g_next
            assign p_vld[i]  = vld_reg[i-1];
            assign p_rem[i]  = rem_reg[i-1];
            assign p_bits[i] = bits_reg[i-1];
            assign p_quo[i]  = quo_reg[i-1];
            assign p_dsr[i]  = dsr_reg[i-1];
            assign p_side[i] = side_reg[i-1];
        end
        assign cand[i] = {p_rem[i], p_bits[i][STEPS-1]};
        assign diff[i] = cand[i] - {1'b0, p_dsr[i]};
        assign take[i] = (cand[i] >= {1'b0, p_dsr[i]});
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= p_vld;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < STEPS; i++)
            begin
                rem_reg[i]  <= take[i] ? diff[i][DSR_W-1:0] : cand[i][DSR_W-1:0];
                bits_reg[i] <= p_bits[i] << 1;
                quo_reg[i]  <= {p_quo[i][QUO_W-2:0], take[i]};
                dsr_reg[i]  <= p_dsr[i];
                side_reg[i] <= p_side[i];
            end
        end
    end

    assign out_valid = vld_reg[STEPS-1];
    assign quotient  = quo_reg[STEPS-1];
    assign remainder = rem_reg[STEPS-1];
    assign out_side  = side_reg[STEPS-1];

endmodule

// ----- hdl/periodic_profile_waveform_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_profile_waveform_top
// Sine, square and triangle profile generator over signed Q16.16 items.
// ----------------------------------------------------------------------------
// The block takes one item per clock while in_ready is high and returns one
// result per item, in order. The pipeline is made of two bit-per-stage
// restoring dividers (the period count with its sine phase bits, then the
// triangle scaling) and the 22-stage fixed-point sine chain between them.
// in_ready drops only while
// the output register holds a result that has not been taken; the whole
// pipeline then holds in place. A wavelength of zero or below returns zero
// with bad_wavelength set, whatever the select.
module periodic_profile_waveform_top #(
    parameter int SINE_PHASE_BITS = 12
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ppw_pkg::ppw_in_t  in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output ppw_pkg::ppw_out_t out_item
);

    import ppw_pkg::*;

    localparam int SPB   = SINE_PHASE_BITS;
    localparam int QB    = SPB - 2;
    localparam int IDX_W = SPB - 1;
    localparam int DV_W  = 34 + SPB;
    localparam int NSC   = 22;
    localparam logic [63:0] X_RND = 64'(1) << (QB - 1);
    localparam logic [IDX_W-1:0] QUARTER = IDX_W'(1) << QB;

    // item context through the sine chain
    typedef struct packed {
        ppw_op_t            op;
        logic               bad;
        logic signed [31:0] a;
        logic [30:0]        w;
        logic signed [31:0] res;
        logic               sneg;
        logic signed [63:0] tnum;
        logic [30:0]        sx;
        logic [31:0]        sx2;
        logic [30:0]        st;
        logic [31:0]        sv;
        logic [63:0]        sm;
    } ctx_t;

    typedef struct packed {
        ppw_op_t            op;
        logic               bad;
        logic               neg;
        logic signed [31:0] a;
        logic [30:0]        w;
    } side1_t;

    typedef struct packed {
        ppw_op_t            op;
        logic               bad;
        logic               neg;
        logic signed [31:0] res;
    } side2_t;

    logic en;

    // stage a: period numerator
    logic               a_vld_reg;
    ppw_op_t            a_op_reg;
    logic               a_bad_reg;
    logic signed [31:0] a_amp_reg;
    logic [30:0]        a_w_reg;
    logic signed [34:0] a_n_reg;
    logic signed [32:0] base;
    logic signed [34:0] a_n_next;

    // stage b: magnitude and dividend
    logic               b_vld_reg;
    side1_t             b_side_reg;
    logic [DV_W-1:0]    b_dvd_reg;
    logic signed [34:0] b_mag_full;
    logic [DV_W-1:0]    b_dvd_next;

    // divider one
    logic               d1_vld;
    logic [SPB-1:0]     d1_q;
    logic [30:0]        d1_rem;
    logic [$bits(side1_t)-1:0] d1_side_bits;
    side1_t             d1_side;

    // stage c: floor correction
    logic               c_vld_reg;
    side1_t             c_side_reg;
    logic [SPB-1:0]     c_ph_reg;
    logic [30:0]        c_r_reg;
    logic               d1_nz;
    logic [SPB-1:0]     c_ph_next;
    logic [30:0]        c_r_next;

    // stage d: quadrant, triangle fold, square
    logic               d_vld_reg;
    ctx_t               d_reg;
    ctx_t               d_next;

    // sine chain
    logic [NSC-1:0]     sc_vld_reg;
    ctx_t               sc_reg  [NSC];
    ctx_t               sc_prev [NSC];
    ctx_t               sc_nxt  [NSC];

    // stage g: triangle dividend magnitude
    logic               g_vld_reg;
    side2_t             g_side_reg;
    logic [63:0]        g_mag_reg;
    logic [31:0]        g_dsr_reg;
    logic [63:0]        g_mag_next;
    logic               g_neg_next;

    // divider two
    logic               d2_vld;
    logic [31:0]        d2_q;
    logic [31:0]        d2_rem;
    logic [$bits(side2_t)-1:0] d2_side_bits;
    side2_t             d2_side;

    // output register
    logic               out_valid_reg;
    ppw_out_t           out_item_reg;
    ppw_out_t           out_item_next;
    logic signed [31:0] tri_val;

    // global advance: hold everything while a result waits
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // numerator for the selected waveform
    always_comb
    begin
        if (in_item.operation == OP_TRIANGLE && in_item.position[31])
        begin
            base = -33'(in_item.position);
        end
        else
        begin
            base = 33'(in_item.position);
        end
        if (in_item.operation == OP_SINE)
        begin
            a_n_next = (35'(base) <<< 1) + 35'(in_item.phase_shift);
        end
        else
        begin
            a_n_next = (35'(base) + 35'(in_item.phase_shift)) <<< 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_op_reg  <= in_item.operation;
            a_bad_reg <= in_item.wavelength[31] || (in_item.wavelength == '0);
            a_amp_reg <= in_item.amplitude;
            a_w_reg   <= in_item.wavelength[30:0];
            a_n_reg   <= a_n_next;
        end
    end

    // dividend magnitude, shifted up by the phase bits for sine
    always_comb
    begin
        b_mag_full = a_n_reg[34] ? -a_n_reg : a_n_reg;
        if (a_op_reg == OP_SINE)
        begin
            b_dvd_next = {b_mag_full[33:0], {SPB{1'b0}}};
        end
        else
        begin
            b_dvd_next = DV_W'(b_mag_full[33:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_side_reg.op  <= a_op_reg;
            b_side_reg.bad <= a_bad_reg;
            b_side_reg.neg <= a_n_reg[34];
            b_side_reg.a   <= a_amp_reg;
            b_side_reg.w   <= a_w_reg;
            b_dvd_reg      <= b_dvd_next;
        end
    end

    // period count and phase bits
    ppw_div #(
        .DSR_W  (31),
        .STEPS  (DV_W),
        .QUO_W  (SPB),
        .SIDE_W ($bits(side1_t))
    ) u_div_period (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (b_vld_reg),
        .init_rem  (31'd0),
        .bits      (b_dvd_reg),
        .divisor   (b_side_reg.w),
        .side      (b_side_reg),
        .out_valid (d1_vld),
        .quotient  (d1_q),
        .remainder (d1_rem),
        .out_side  (d1_side_bits)
    );

    assign d1_side = side1_t'(d1_side_bits);

    // floor quotient and remainder for a negative dividend
    always_comb
    begin
        d1_nz = (d1_rem != '0);
        if (d1_side.neg)
        begin
            c_ph_next = d1_nz ? ~d1_q : -d1_q;
            c_r_next  = d1_nz ? (d1_side.w - d1_rem) : '0;
        end
        else
        begin
            c_ph_next = d1_q;
            c_r_next  = d1_rem;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_side_reg <= d1_side;
            c_ph_reg   <= c_ph_next;
            c_r_reg    <= c_r_next;
        end
    end

    // quarter-wave index, triangle fold and square level
    always_comb
    begin
        logic [1:0]         quad;
        logic [QB-1:0]      rr;
        logic [IDX_W-1:0]   idx;
        logic               parity;
        logic [30:0]        m;
        logic signed [32:0] t2;
        logic signed [31:0] h;

        quad   = c_ph_reg[SPB-1:SPB-2];
        rr     = c_ph_reg[QB-1:0];
        idx    = quad[0] ? (QUARTER - IDX_W'(rr)) : IDX_W'(rr);
        parity = c_ph_reg[0];
        m      = parity ? (c_side_reg.w - c_r_reg) : c_r_reg;
        t2     = signed'({1'b0, m, 1'b0}) - signed'({2'b00, c_side_reg.w});
        h      = c_side_reg.a >>> 1;

        d_next      = '0;
        d_next.op   = c_side_reg.op;
        d_next.bad  = c_side_reg.bad;
        d_next.a    = c_side_reg.a;
        d_next.w    = c_side_reg.w;
        d_next.sneg = quad[1];
        d_next.sm   = 64'(idx);
        d_next.tnum = 64'(t2);
        if (c_side_reg.op == OP_SQUARE)
        begin
            d_next.res = parity ? -h : h;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    // sine chain: angle, square, five horner terms, final scale; also carries the triangle numerator
    for (genvar k = 0; k < NSC; k++)
    begin : g_sc
        if (k == 0)
        begin : g_src_d
            assign sc_prev[k] = d_reg;
        end
        else
        begin : g_src_sc
            assign sc_prev[k] = sc_reg[k-1];
        end

        if (k == 0)
        begin : g_angle_mul
            // quarter index times pi/2, and triangle ramp times amplitude
            always_comb
            begin
                sc_nxt[k]      = sc_prev[k];
                sc_nxt[k].sm   = 64'(sc_prev[k].sm[IDX_W-1:0]) * 64'(HALF_PI_Q30);
                sc_nxt[k].tnum = 64'(signed'(sc_prev[k].tnum[31:0])) * 64'(sc_prev[k].a);
            end
        end
        else if (k == 1)
        begin : g_angle_rnd
            // rounded angle in q30
            always_comb
            begin
                logic [63:0] rsum;
                rsum         = sc_prev[k].sm + X_RND;
                sc_nxt[k]    = sc_prev[k];
                sc_nxt[k].sx = rsum[QB+30:QB];
            end
        end
        else if (k == 2)
        begin : g_sq
            // x squared in q30, horner seed
            always_comb
            begin
                logic [61:0] sq;
                sq            = 62'(sc_prev[k].sx) * 62'(sc_prev[k].sx);
                sc_nxt[k]     = sc_prev[k];
                sc_nxt[k].sx2 = sq[61:30];
                sc_nxt[k].st  = Q30_ONE;
            end
        end
        else if (k < 3 + 3 * HORNER_TERMS)
        begin : g_horner
            localparam int HJ = (k - 3) / 3;
            localparam int HP = (k - 3) % 3;
            if (HP == 0)
            begin : g_mul
                // x^2 times running term
                always_comb
                begin
                    sc_nxt[k]    = sc_prev[k];
                    sc_nxt[k].sm = 64'(sc_prev[k].sx2) * 64'(sc_prev[k].st);
                end
            end
            else if (HP == 1)
            begin : g_recip
                // estimate quotient by reciprocal
                always_comb
                begin
                    sc_nxt[k]    = sc_prev[k];
                    sc_nxt[k].sv = sc_prev[k].sm[61:30];
                    sc_nxt[k].sm = 64'(sc_prev[k].sm[61:30]) * 64'(HORNER_RECIP[HJ]);
                end
            end
            else
            begin : g_fix
                // one-step quotient correction, then 1 - q
                always_comb
                begin
                    logic [29:0] q0;
                    logic [32:0] back;
                    logic [32:0] rem;
                    logic [30:0] q;
                    q0           = sc_prev[k].sm[63:34];
                    back         = 33'(q0) * 33'(HORNER_DEN[HJ]);
                    rem          = 33'(sc_prev[k].sv) - back;
                    q            = 31'(q0) + 31'(rem >= 33'(HORNER_DEN[HJ]));
                    sc_nxt[k]    = sc_prev[k];
                    sc_nxt[k].st = Q30_ONE - q;
                end
            end
        end
        else if (k == NSC - 4)
        begin : g_xt
            // x times series
            always_comb
            begin
                sc_nxt[k]    = sc_prev[k];
                sc_nxt[k].sm = 64'(sc_prev[k].sx) * 64'(sc_prev[k].st);
            end
        end
        else if (k == NSC - 3)
        begin : g_clamp
            // clamp to one and apply half-wave sign
            always_comb
            begin
                logic [31:0] tmag;
                logic [30:0] mag;
                tmag = sc_prev[k].sm[61:30];
                mag  = (tmag > 32'(Q30_ONE)) ? Q30_ONE : tmag[30:0];
                sc_nxt[k]    = sc_prev[k];
                sc_nxt[k].sv = sc_prev[k].sneg ? -32'(mag) : 32'(mag);
            end
        end
        else if (k == NSC - 2)
        begin : g_amp
            // sine times amplitude
            always_comb
            begin
                sc_nxt[k]    = sc_prev[k];
                sc_nxt[k].sm = 64'(signed'(sc_prev[k].sv)) * 64'(sc_prev[k].a);
            end
        end
        else
        begin : g_out
            // round sine result, add w to triangle numerator
            always_comb
            begin
                logic [63:0] rsum;
                rsum           = sc_prev[k].sm + 64'(Q30_ONE);
                sc_nxt[k]      = sc_prev[k];
                sc_nxt[k].tnum = sc_prev[k].tnum + signed'(64'(sc_prev[k].w));
                if (sc_prev[k].op == OP_SINE)
                begin
                    sc_nxt[k].res = signed'(rsum[62:31]);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NSC; k++)
            begin
                sc_reg[k] <= sc_nxt[k];
            end
        end
    end

    // triangle dividend magnitude
    assign g_neg_next = sc_reg[NSC-1].tnum[63];
    assign g_mag_next = g_neg_next ? 64'(-sc_reg[NSC-1].tnum) : 64'(sc_reg[NSC-1].tnum);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_side_reg.op  <= sc_reg[NSC-1].op;
            g_side_reg.bad <= sc_reg[NSC-1].bad;
            g_side_reg.neg <= g_neg_next;
            g_side_reg.res <= sc_reg[NSC-1].res;
            g_mag_reg      <= g_mag_next;
            g_dsr_reg      <= {sc_reg[NSC-1].w, 1'b0};
        end
    end

    // triangle scaling by 2w
    ppw_div #(
        .DSR_W  (32),
        .STEPS  (33),
        .QUO_W  (32),
        .SIDE_W ($bits(side2_t))
    ) u_div_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (g_vld_reg),
        .init_rem  ({1'b0, g_mag_reg[63:33]}),
        .bits      (g_mag_reg[32:0]),
        .divisor   (g_dsr_reg),
        .side      (g_side_reg),
        .out_valid (d2_vld),
        .quotient  (d2_q),
        .remainder (d2_rem),
        .out_side  (d2_side_bits)
    );

    assign d2_side = side2_t'(d2_side_bits);

    // final select
    always_comb
    begin
        if (d2_side.neg)
        begin
            tri_val = (d2_rem != '0) ? signed'(~d2_q) : signed'(-d2_q);
        end
        else
        begin
            tri_val = signed'(d2_q);
        end
        out_item_next.bad_wavelength = d2_side.bad;
        out_item_next.value          = '0;
        if (!d2_side.bad)
        begin
            unique case (d2_side.op)
                OP_NONE:     out_item_next.value = '0;
                OP_SINE:     out_item_next.value = d2_side.res;
                OP_SQUARE:   out_item_next.value = d2_side.res;
                OP_TRIANGLE: out_item_next.value = tri_val;
                default:     out_item_next.value = '0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_item_reg <= out_item_next;
        end
    end

    // valid bits of the local stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg     <= 1'b0;
            b_vld_reg     <= 1'b0;
            c_vld_reg     <= 1'b0;
            d_vld_reg     <= 1'b0;
            sc_vld_reg    <= '0;
            g_vld_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg     <= in_valid;
            b_vld_reg     <= a_vld_reg;
            c_vld_reg     <= d1_vld;
            d_vld_reg     <= c_vld_reg;
            sc_vld_reg    <= {sc_vld_reg[NSC-2:0], d_vld_reg};
            g_vld_reg     <= sc_vld_reg[NSC-1];
            out_valid_reg <= d2_vld;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // a bad wavelength always yields zero
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.bad_wavelength |-> out_item.value == '0)
        else $error("bad wavelength item with nonzero value");

    // an empty output register never blocks input
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // floor remainder stays below the wavelength
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        c_vld_reg && !c_side_reg.bad |-> c_r_reg < c_side_reg.w)
        else $error("period remainder out of range");

    // clamped sine within plus or minus one
    a_sine_range: assert property (@(posedge clk) disable iff (!rst_n)
        sc_vld_reg[NSC-3] |->
            (signed'(sc_reg[NSC-3].sv) <= signed'(32'(Q30_ONE))) &&
            (signed'(sc_reg[NSC-3].sv) >= -signed'(32'(Q30_ONE))))
        else $error("sine magnitude above one");

endmodule

// ----- verif/profile_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// profile_checker
// Watches both channels of the profile generator, computes the expected
// profile value of every accepted input item and compares the results.
// ----------------------------------------------------------------------------
module profile_checker
    import ppw_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_ready,
    input  ppw_in_t  in_item,
    input  logic     out_valid,
    input  logic     out_ready,
    input  ppw_out_t out_item,
    output int       fail_count,
    output int       pending,
    output int       results_seen
);

    localparam int PHASE_BITS = 12;

    ppw_out_t expected_profiles[$];

    // floor division for positive divisor
    function automatic longint floor_quot(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0)
            q = q - 1;
        return q;
    endfunction

    // quarter-wave sine in q30, index in quarter steps
    function automatic longint unsigned sine_q30(longint unsigned idx);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned dens[5];
        dens = '{110, 72, 42, 20, 6};
        x = (idx * 64'd1686629713 + ((64'd1 << (PHASE_BITS - 2)) >> 1))
            >> (PHASE_BITS - 2);
        x2 = (x * x) >> 30;
        t = 64'd1 << 30;
        for (int i = 0; i < 5; i++)
            t = (64'd1 << 30) - ((x2 * t) >> 30) / dens[i];
        t = (x * t) >> 30;
        return (t > (64'd1 << 30)) ? (64'd1 << 30) : t;
    endfunction

    function automatic ppw_out_t profile_of(ppw_in_t it);
        ppw_out_t r;
        longint p, a, s, w, v, k, n, m, rem, sv;
        longint unsigned ph, quad, qr, mag;
        p = it.position;
        a = it.amplitude;
        s = it.phase_shift;
        w = it.wavelength;
        v = 0;
        r.bad_wavelength = (w <= 0);
        if (w > 0) begin
            case (it.operation)
                OP_SINE:
                begin
                    ph = longint'(floor_quot((2 * p + s) * (64'sd1 << PHASE_BITS), w))
                        & ((64'd1 << PHASE_BITS) - 1);
                    quad = ph >> (PHASE_BITS - 2);
                    qr = ph & ((64'd1 << (PHASE_BITS - 2)) - 1);
                    mag = quad[0] ? sine_q30((64'd1 << (PHASE_BITS - 2)) - qr)
                                  : sine_q30(qr);
                    sv = quad[1] ? -longint'(mag) : longint'(mag);
                    v = (sv * a + (64'sd1 <<< 30)) >>> 31;
                end
                OP_SQUARE:
                begin
                    k = floor_quot(2 * (p + s), w);
                    v = k[0] ? -(a >>> 1) : (a >>> 1);
                end
                OP_TRIANGLE:
                begin
                    n = 2 * (((p < 0) ? -p : p) + s);
                    k = floor_quot(n, w);
                    rem = n - k * w;
                    m = k[0] ? w - rem : rem;
                    v = floor_quot((2 * m - w) * a + w, 2 * w);
                end
                default: v = 0;
            endcase
        end
        r.value = v[31:0];
        return r;
    endfunction

    assign pending = expected_profiles.size();

    // predict on input item, compare on result item
    always @(posedge clk or negedge rst_n)
    begin
        ppw_out_t exp_item;
        int errs;
        if (!rst_n)
        begin
            fail_count <= 0;
            results_seen <= 0;
        end
        else
        begin
            errs = 0;
            if (in_valid && in_ready)
                expected_profiles.push_back(profile_of(in_item));
            if (out_valid && out_ready)
            begin
                results_seen <= results_seen + 1;
                if (expected_profiles.size() == 0)
                begin
                    $error("unexpected result item value=%0d", out_item.value);
                    errs++;
                end
                else
                begin
                    exp_item = expected_profiles.pop_front();
                    if (out_item.value !== exp_item.value)
                    begin
                        $error("value expected %0d actual %0d",
                               exp_item.value, out_item.value);
                        errs++;
                    end
                    if (out_item.bad_wavelength !== exp_item.bad_wavelength)
                    begin
                        $error("bad_wavelength expected %0b actual %0b",
                               exp_item.bad_wavelength, out_item.bad_wavelength);
                        errs++;
                    end
                end
            end
            if (errs != 0)
                fail_count <= fail_count + errs;
        end
    end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random waveform items into the profile generator with
// random gaps and stalls and long output hold-offs, and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
    import ppw_pkg::*;

    localparam int RANDOM_ITEMS = 1700;
    localparam int LATENCY = 107;
    localparam int IDLE_LIMIT = 5000;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_ready;
    ppw_in_t  in_item = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    ppw_out_t out_item;
    int       fail_count;
    int       pending;
    int       results_seen;
    int       sent = 0;
    bit       stim_done = 0;
    int       idle_cycles = 0;

    always #2 clk = ~clk;

    periodic_profile_waveform_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
        .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
    );

    profile_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
        .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
        .fail_count(fail_count), .pending(pending), .results_seen(results_seen)
    );

    // random 32-bit field, biased toward edges
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000 + $urandom_range(0, 3);
            1: return 32'h7fff_ffff - $urandom_range(0, 3);
            2: return $urandom_range(0, 8) - 4;
            3: return $urandom();
            default: return $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
        endcase
    endfunction

    // one item: hold valid until accepted, then wait a random gap
    task automatic send_item(ppw_op_t op, logic [31:0] p, logic [31:0] a,
                             logic [31:0] s, logic [31:0] w, int gap);
        in_item <= '{op, p, a, s, w};
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent++;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // receiver: random stalls, long hold-offs around the two hundredth result
    initial
    begin
        int wait_n;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (results_seen > 200 && results_seen < 205)
                wait_n = 400;
            else
                wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
            if (wait_n > 0)
            begin
                out_ready <= 1'b0;
                repeat (wait_n) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    // watchdog on accepted items
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("** periodic_profile_waveform_top: FAILED **");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] w;
        int gap;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        // directed: each select, extremes, bad wavelengths
        for (int op = 0; op < 4; op++)
        begin
            send_item(ppw_op_t'(op), 32'h0001_0000, 32'h0002_0000, 0, 32'h0004_0000, 0);
            send_item(ppw_op_t'(op), 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                      32'h0000_0001, 0);
            send_item(ppw_op_t'(op), 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                      32'h7fff_ffff, 1);
            send_item(ppw_op_t'(op), 32'hffff_0000, 32'hffff_ffff, 32'hfff0_0000, 0, 0);
            send_item(ppw_op_t'(op), 32'h0003_0000, 32'h0001_0000, 32'h0001_0000,
                      32'h8000_0000, 0);
            send_item(ppw_op_t'(op), 32'hfffc_8000, 32'h0010_0000, 32'h0000_4000,
                      32'h0001_8000, 2);
        end
        // random part, wavelength mostly positive
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            w = pick_word();
            if ($urandom_range(0, 9) != 0)
                w[31] = 1'b0;
            if (w == 0 && $urandom_range(0, 1))
                w = 1;
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5);
            if (i > 800 && i < 1000)
                gap = 0;
            send_item(ppw_op_t'($urandom_range(0, 3)), pick_word(), pick_word(),
                      pick_word(), w, gap);
        end
        in_valid <= 1'b0;
        stim_done = 1;
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        $display("sent %0d items over all four selects, %0d results checked",
                 sent, results_seen);
        $display("covered extreme fields, bad wavelengths, gaps and a long stall");
        if (fail_count == 0 && pending == 0)
            $display("** periodic_profile_waveform_top: PASSED **");
        else
            $display("** periodic_profile_waveform_top: FAILED **");
        $finish;
    end

endmodule
